// ===== sv/hitl_pkg.sv =====
// hitl_pkg: shared constants, types and hash helpers for the hashed id table
// used by hitl_hash, hitl_probe and hashed_id_table_insert_lookup
package hitl_pkg;

    localparam int SLOT_BITS  = 12;
    localparam int SLOT_DEPTH = 1 << SLOT_BITS;
    localparam int SLOT_IDX_W = 12;
    localparam int ORD_W      = 32;
    localparam int LOG2_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int KEY_W      = 128;

    localparam logic [LOG2_W-1:0] LOG2_RESET = 4'd12;

    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
    localparam logic [63:0] SEED_LOW  = 64'h1465_0fb0_739d_0383;
    localparam logic [63:0] SEED_HIGH = 64'h0000_0100_0000_01b3 ^ 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_A     = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] MIX_B     = 64'hc4ce_b9fe_1a85_ec53;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [ORD_W-1:0] ORD_RESERVED = '1;

    typedef logic [SLOT_BITS-1:0] t_slot;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_SAME     = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_FULL     = 3'd3,
        ST_FOUND    = 3'd4,
        ST_MISSING  = 3'd5
    } t_status;

    typedef struct packed {
        logic [63:0]      key_high;
        logic [63:0]      key_low;
        logic             command;
        logic [ORD_W-1:0] ordinal;
    } t_key_req;

    // fnv-1a step; prime is 2^40 + 0x1b3
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] n;
        n = h ^ {56'd0, b};
        return (n << 40) + (n * 64'h1b3);
    endfunction

    function automatic logic [63:0] fold33(input logic [63:0] x);
        return x ^ (x >> 33);
    endfunction

    function automatic t_slot slot_mask(input logic [LOG2_W-1:0] log2);
        t_slot m;
        for (int i = 0; i < SLOT_BITS; i++) begin
            m[i] = (i < int'(log2));
        end
        return m;
    endfunction

endpackage

// ===== sv/hitl_ram.sv =====
// hitl_ram: generic single write port ram with a registered read port
// no dependencies
module hitl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/hitl_hash.sv =====
// hitl_hash: two fnv-1a lanes fed one byte per word, fmix64 finalizer per lane
// depends on hitl_pkg; hands the 128-bit key to hitl_probe
module hitl_hash import hitl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_command,
    input  logic [ORD_W-1:0] i_ordinal,
    input  logic             i_hold,
    output logic             o_key_valid,
    input  logic             i_key_ready,
    output t_key_req         o_key
);

    logic [63:0]      r_lane_lo, r_lane_hi;
    logic             r_busy, r_key_valid;
    logic [2:0]       r_cnt;
    logic [63:0]      r_x_lo, r_x_hi, r_p_lo, r_p_hi, r_acc_lo, r_acc_hi;
    logic             r_cmd;
    logic [ORD_W-1:0] r_ord;

    logic        accept;
    logic [63:0] fnv_lo, fnv_hi, mix_c, prod_lo, prod_hi, fin_lo, fin_hi;
    logic [1:0]  k;
    logic [31:0] op_b, op_a_lo, op_a_hi;

    assign o_ready = !r_busy && !r_key_valid && !i_hold;
    assign accept  = i_valid && o_ready;
    assign fnv_lo  = fnv_step(r_lane_lo, i_byte);
    assign fnv_hi  = fnv_step(r_lane_hi, i_byte);

    // step k of one 64x64 low-half product: lo*lo, lo*hi, hi*lo, then sum
    assign k       = r_cnt[1:0];
    assign mix_c   = r_cnt[2] ? MIX_B : MIX_A;
    assign op_b    = (k == 2'd1) ? mix_c[63:32] : mix_c[31:0];
    assign op_a_lo = k[1] ? r_x_lo[63:32] : r_x_lo[31:0];
    assign op_a_hi = k[1] ? r_x_hi[63:32] : r_x_hi[31:0];
    assign prod_lo = {32'd0, op_a_lo} * {32'd0, op_b};
    assign prod_hi = {32'd0, op_a_hi} * {32'd0, op_b};
    assign fin_lo  = {r_acc_lo[63:32] + r_p_lo[31:0], r_acc_lo[31:0]};
    assign fin_hi  = {r_acc_hi[63:32] + r_p_hi[31:0], r_acc_hi[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_lo   <= SEED_LOW;
            r_lane_hi   <= SEED_HIGH;
            r_busy      <= 1'b0;
            r_key_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (accept) begin
                if (i_last) begin
                    r_lane_lo <= SEED_LOW;
                    r_lane_hi <= SEED_HIGH;
                    r_busy    <= 1'b1;
                    r_cnt     <= '0;
                end else begin
                    r_lane_lo <= fnv_lo;
                    r_lane_hi <= fnv_hi;
                end
            end
            if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy      <= 1'b0;
                    r_key_valid <= 1'b1;
                end
            end
            if (r_key_valid && i_key_ready) begin
                r_key_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_x_lo <= fold33(fnv_lo);
            r_x_hi <= fold33(fnv_hi);
            r_cmd  <= i_command;
            r_ord  <= i_ordinal;
        end else if (r_busy) begin
            case (k)
                2'd0: begin
                    r_p_lo <= prod_lo;
                    r_p_hi <= prod_hi;
                end
                2'd1: begin
                    r_acc_lo <= r_p_lo;
                    r_acc_hi <= r_p_hi;
                    r_p_lo   <= prod_lo;
                    r_p_hi   <= prod_hi;
                end
                2'd2: begin
                    r_acc_lo[63:32] <= r_acc_lo[63:32] + r_p_lo[31:0];
                    r_acc_hi[63:32] <= r_acc_hi[63:32] + r_p_hi[31:0];
                    r_p_lo          <= prod_lo;
                    r_p_hi          <= prod_hi;
                end
                default: begin
                    r_x_lo <= fold33(fin_lo);
                    r_x_hi <= fold33(fin_hi);
                end
            endcase
        end
    end

    assign o_key_valid    = r_key_valid;
    assign o_key.key_low  = r_x_lo;
    assign o_key.key_high = r_x_hi;
    assign o_key.command  = r_cmd;
    assign o_key.ordinal  = r_ord;

endmodule

// ===== sv/hitl_probe.sv =====
// hitl_probe: clearing pass, linear probe over the slot rams, result register
// depends on hitl_pkg and hitl_ram
module hitl_probe import hitl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [LOG2_W-1:0]     i_slot_log2,
    input  logic                  i_key_valid,
    output logic                  o_key_ready,
    input  t_key_req              i_key,
    output logic                  o_clearing,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output t_status               o_status,
    output logic [ORD_W-1:0]      o_found_ordinal,
    output logic [SLOT_IDX_W-1:0] o_slot_index
);

    typedef enum logic [2:0] {
        PS_CLEAR = 3'b001,
        PS_IDLE  = 3'b010,
        PS_PROBE = 3'b100
    } t_probe_state;

    t_probe_state     r_state, n_state;
    t_slot            r_idx, n_idx, r_cnt, n_cnt, r_mask, r_clr_addr;
    logic [63:0]      r_klo, r_khi;
    logic             r_cmd;
    logic [ORD_W-1:0] r_ord;
    logic             r_m_valid;
    t_status          r_m_status, n_status;
    logic [ORD_W-1:0] r_m_ord, n_ord;
    t_slot            r_m_slot, n_slot;

    logic             key_take, used, hit, reserved, out_free, term, want_write, load;
    logic [KEY_W-1:0] key_rd;
    logic [ORD_W-1:0] ord_rd, stored;
    logic             key_we, ord_we;
    t_slot            ord_waddr;
    logic [ORD_W-1:0] ord_wdata;

    hitl_ram #(.WIDTH(KEY_W), .DEPTH(SLOT_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_idx),
        .i_wdata ({r_khi, r_klo}),
        .i_raddr (n_idx),
        .o_rdata (key_rd)
    );

    hitl_ram #(.WIDTH(ORD_W), .DEPTH(SLOT_DEPTH)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (n_idx),
        .o_rdata (ord_rd)
    );

    assign o_key_ready = (r_state == PS_IDLE);
    assign o_clearing  = (r_state == PS_CLEAR);
    assign key_take    = (r_state == PS_IDLE) && i_key_valid;
    assign used        = (ord_rd != '0);
    assign hit         = (key_rd == {r_khi, r_klo});
    assign stored      = ord_rd - 32'd1;
    assign reserved    = (r_cmd == CMD_INSERT) && (r_ord == ORD_RESERVED);
    assign out_free    = !r_m_valid || i_m_ready;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_status   = ST_MISSING;
        n_ord      = '0;
        n_slot     = '0;
        term       = 1'b0;
        want_write = 1'b0;
        case (r_state)
            PS_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = PS_IDLE;
                end
            end
            PS_IDLE: begin
                if (key_take) begin
                    n_state = PS_PROBE;
                    n_idx   = i_key.key_low[SLOT_BITS-1:0] & slot_mask(i_slot_log2);
                    n_cnt   = '0;
                end
            end
            PS_PROBE: begin
                if (reserved) begin
                    term     = 1'b1;
                    n_status = ST_FULL;
                end else if (!used) begin
                    term = 1'b1;
                    if (r_cmd == CMD_INSERT) begin
                        want_write = 1'b1;
                        n_status   = ST_INSERTED;
                        n_ord      = r_ord;
                        n_slot     = r_idx;
                    end
                end else if (hit) begin
                    term   = 1'b1;
                    n_ord  = stored;
                    n_slot = r_idx;
                    if (r_cmd == CMD_LOOKUP) begin
                        n_status = ST_FOUND;
                    end else if (stored == r_ord) begin
                        n_status = ST_SAME;
                    end else begin
                        n_status = ST_CONFLICT;
                    end
                end else if (r_cnt == r_mask) begin
                    term     = 1'b1;
                    n_status = (r_cmd == CMD_INSERT) ? ST_FULL : ST_MISSING;
                end else begin
                    n_idx = (r_idx + 1'b1) & r_mask;
                    n_cnt = r_cnt + 1'b1;
                end
                if (term && out_free) begin
                    n_state = PS_IDLE;
                end
            end
            default: begin
                n_state = PS_IDLE;
            end
        endcase
    end

    assign load      = (r_state == PS_PROBE) && term && out_free;
    assign key_we    = load && want_write;
    assign ord_we    = (r_state == PS_CLEAR) || key_we;
    assign ord_waddr = (r_state == PS_CLEAR) ? r_clr_addr : r_idx;
    assign ord_wdata = (r_state == PS_CLEAR) ? '0 : r_ord + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= PS_CLEAR;
            r_clr_addr <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == PS_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_cnt <= n_cnt;
        if (key_take) begin
            r_klo  <= i_key.key_low;
            r_khi  <= i_key.key_high;
            r_cmd  <= i_key.command;
            r_ord  <= i_key.ordinal;
            r_mask <= slot_mask(i_slot_log2);
        end
        if (load) begin
            r_m_status <= n_status;
            r_m_ord    <= n_ord;
            r_m_slot   <= n_slot;
        end
    end

    assign o_m_valid       = r_m_valid;
    assign o_status        = r_m_status;
    assign o_found_ordinal = r_m_ord;
    assign o_slot_index    = SLOT_IDX_W'(r_m_slot);

endmodule

// ===== sv/hashed_id_table_insert_lookup.sv =====
// hashed_id_table_insert_lookup: top level of the hashed id table
// depends on hitl_pkg, hitl_hash, hitl_probe (and hitl_ram through hitl_probe)
//
//   group    | dir | tdata                              | tuser        | tlast
//   s_axis   | in  | [7:0] id_byte, [39:8] ordinal      | command      | last_byte
//   m_axis   | out | [31:0] found_ordinal, [43:32] slot | [2:0] status | -
//   i_cfg_wr | in  | [3:0] slot_count_log2              | -            | -
//
// a byte word that is not last steps both fnv lanes; a last byte starts the
// fmix finalizer (one 32x32 multiplier step per lane per cycle), then the key
// is handed to the prober, and each slot probed costs one slot ram read.
// after reset a clearing pass empties the ordinal ram; no word is accepted
// on s_axis until it ends.
// a stalled m_axis holds the prober at its final slot until the result drains.
module hashed_id_table_insert_lookup import hitl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // id_byte, ordinal
    input  logic              s_axis_tuser,   // command
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // found_ordinal, slot_index, zero fill
    output logic [2:0]        m_axis_tuser,   // status
    input  logic              i_cfg_wr_en,
    input  logic [LOG2_W-1:0] i_cfg_wr_data
);

    logic [LOG2_W-1:0]     r_slot_log2;
    logic                  key_valid, key_ready, clearing;
    t_key_req              key;
    t_status               status;
    logic [ORD_W-1:0]      found_ordinal;
    logic [SLOT_IDX_W-1:0] slot_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_log2 <= LOG2_RESET;
        end else if (i_cfg_wr_en) begin
            r_slot_log2 <= i_cfg_wr_data;
        end
    end

    hitl_hash u_hash (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata[7:0]),
        .i_last      (s_axis_tlast),
        .i_command   (s_axis_tuser),
        .i_ordinal   (s_axis_tdata[39:8]),
        .i_hold      (clearing),
        .o_key_valid (key_valid),
        .i_key_ready (key_ready),
        .o_key       (key)
    );

    hitl_probe u_probe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_slot_log2     (r_slot_log2),
        .i_key_valid     (key_valid),
        .o_key_ready     (key_ready),
        .i_key           (key),
        .o_clearing      (clearing),
        .o_m_valid       (m_axis_tvalid),
        .i_m_ready       (m_axis_tready),
        .o_status        (status),
        .o_found_ordinal (found_ordinal),
        .o_slot_index    (slot_index)
    );

    assign m_axis_tdata = {4'd0, slot_index, found_ordinal};
    assign m_axis_tuser = status;

endmodule

// ===== tb/tb_hashed_id_table_insert_lookup.sv =====
`timescale 1ns / 1ps
// tb_hashed_id_table_insert_lookup: self-checking bench for the hashed id table, driving id byte
// words and table size writes and checking every answer word against an in-bench table model
// depends on hitl_pkg and hashed_id_table_insert_lookup
module tb_hashed_id_table_insert_lookup;
    import hitl_pkg::*;

    localparam logic [63:0] FNV_MUL   = 64'd1099511628211;
    localparam logic [63:0] OFFSET_LO = 64'd1469598103934665603;
    localparam logic [63:0] OFFSET_HI = 64'd1099511628211 ^ 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] AVAL_A    = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] AVAL_B    = 64'hc4ce_b9fe_1a85_ec53;

    localparam int SETTLE       = 16;
    localparam int POOL         = 40;
    localparam int PHASE_WORDS  = 150;
    localparam int RANDOM_WORDS = 1800;
    localparam int ROWS         = 26;

    typedef struct packed {
        t_status                 status;
        logic [ORD_W-1:0]        ord;
        logic [SLOT_IDX_W-1:0]   slot;
    } t_answer;

    typedef enum logic [1:0] {ROW_WORD, ROW_SIZE} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic             cmd;
        logic [7:0]       id;
        logic             last;
        logic [ORD_W-1:0] ord;
        logic             typed;
        t_answer          fixed;
    } t_row;

    typedef struct packed {
        logic [7:0][7:0]  text;
        logic [2:0]       len_m1;
        logic [ORD_W-1:0] ord;
    } t_ident;

    localparam t_answer NO_ANSWER = '{ST_INSERTED, 32'd0, 12'd0};

    localparam t_row PLAN [0:ROWS-1] = '{
        '{ROW_WORD, CMD_LOOKUP, 8'h00, 1'b1, 32'h0000_0000, 1'b1, '{ST_MISSING, 32'd0, 12'd0}},
        '{ROW_WORD, CMD_INSERT, 8'hff, 1'b1, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'hff, 1'b1, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'hff, 1'b1, 32'hffff_fffe, 1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'hff, 1'b1, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'h5a, 1'b0, 32'hffff_ffff, 1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'ha5, 1'b1, 32'hffff_fffe, 1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'h11, 1'b1, 32'hffff_ffff, 1'b1, '{ST_FULL, 32'd0, 12'd0}},
        '{ROW_WORD, CMD_LOOKUP, 8'h11, 1'b1, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'h00, 1'b0, 32'h8000_0001, 1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'h80, 1'b1, 32'h0000_0000, 1'b0, NO_ANSWER},
        '{ROW_SIZE, CMD_INSERT, 8'h00, 1'b0, 32'd0,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'h22, 1'b1, 32'd7,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'h33, 1'b1, 32'd8,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'h44, 1'b1, 32'd0,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'h22, 1'b1, 32'd0,         1'b0, NO_ANSWER},
        '{ROW_SIZE, CMD_INSERT, 8'h00, 1'b0, 32'd15,        1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'hff, 1'b1, 32'd0,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'h5a, 1'b0, 32'd0,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'ha5, 1'b1, 32'd0,         1'b0, NO_ANSWER},
        '{ROW_SIZE, CMD_INSERT, 8'h00, 1'b0, 32'd1,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'h01, 1'b1, 32'd1,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'h02, 1'b1, 32'd2,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'h03, 1'b1, 32'd3,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_INSERT, 8'h04, 1'b1, 32'd4,         1'b0, NO_ANSWER},
        '{ROW_WORD, CMD_LOOKUP, 8'h05, 1'b1, 32'd0,         1'b0, NO_ANSWER}
    };

    localparam logic [LOG2_W-1:0] SIZE_SEQ [0:11] = '{
        4'd12, 4'd3, 4'd0, 4'd15, 4'd2, 4'd7, 4'd1, 4'd13, 4'd4, 4'd12, 4'd5, 4'd14
    };

    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              s_axis_tvalid  = 1'b0;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata   = '0;   // id_byte, ordinal
    logic              s_axis_tuser   = 1'b0; // command
    logic              s_axis_tlast   = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready  = 1'b0;
    logic [47:0]       m_axis_tdata;          // found_ordinal, slot_index, zero fill
    logic [2:0]        m_axis_tuser;          // status
    logic              i_cfg_wr_en    = 1'b0;
    logic [LOG2_W-1:0] i_cfg_wr_data  = '0;

    hashed_id_table_insert_lookup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // table model state
    logic [63:0]       lane_lo   = OFFSET_LO;
    logic [63:0]       lane_hi   = OFFSET_HI;
    logic [63:0]       key_lo_mem [SLOT_DEPTH];
    logic [63:0]       key_hi_mem [SLOT_DEPTH];
    logic [ORD_W-1:0]  ord_plus_one_mem [SLOT_DEPTH];
    logic [LOG2_W-1:0] size_log2 = LOG2_RESET;

    t_answer answers_due [$];
    t_answer seen, due;
    t_ident  names [POOL];
    bit      steady = 1'b0;
    int      words_sent = 0;
    int      results_seen = 0;
    int      mismatches = 0;
    int      status_tally [6] = '{0, 0, 0, 0, 0, 0};

    function automatic logic [63:0] avalanche(input logic [63:0] h);
        h = h ^ (h >> 33);
        h = h * AVAL_A;
        h = h ^ (h >> 33);
        h = h * AVAL_B;
        return h ^ (h >> 33);
    endfunction

    function automatic bit apply_word(input logic cmd, input logic [7:0] b, input logic last,
                                      input logic [ORD_W-1:0] ord, output t_answer ans);
        logic [63:0] klo, khi;
        int unsigned bits, count, mask, idx;
        ans = NO_ANSWER;
        lane_lo = (lane_lo ^ {56'd0, b}) * FNV_MUL;
        lane_hi = (lane_hi ^ {56'd0, b}) * FNV_MUL;
        if (!last) return 1'b0;
        klo = avalanche(lane_lo);
        khi = avalanche(lane_hi);
        lane_lo = OFFSET_LO;
        lane_hi = OFFSET_HI;
        bits = (size_log2 > SLOT_BITS) ? SLOT_BITS : size_log2;
        count = 1 << bits;
        mask = count - 1;
        if (cmd == CMD_INSERT && ord == ORD_RESERVED) begin
            ans.status = ST_FULL;
            return 1'b1;
        end
        idx = klo[31:0] & mask;
        for (int unsigned p = 0; p < count; p++) begin
            if (ord_plus_one_mem[idx] == '0) begin
                if (cmd == CMD_INSERT) begin
                    key_lo_mem[idx] = klo;
                    key_hi_mem[idx] = khi;
                    ord_plus_one_mem[idx] = ord + 1;
                    ans = '{ST_INSERTED, ord, SLOT_IDX_W'(idx)};
                end else begin
                    ans.status = ST_MISSING;
                end
                return 1'b1;
            end
            if (key_lo_mem[idx] == klo && key_hi_mem[idx] == khi) begin
                ans.ord = ord_plus_one_mem[idx] - 1;
                ans.slot = SLOT_IDX_W'(idx);
                if (cmd == CMD_LOOKUP) ans.status = ST_FOUND;
                else ans.status = (ans.ord == ord) ? ST_SAME : ST_CONFLICT;
                return 1'b1;
            end
            idx = (idx + 1) & mask;
        end
        ans.status = (cmd == CMD_INSERT) ? ST_FULL : ST_MISSING;
        return 1'b1;
    endfunction

    function automatic t_ident fresh_ident();
        t_ident w;
        w.text = {$urandom, $urandom};
        w.len_m1 = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 4));
        w.ord = $urandom;
        return w;
    endfunction

    task automatic send_word(input logic cmd, input logic [7:0] b, input logic last,
                             input logic [ORD_W-1:0] ord);
        if (!steady && $urandom_range(0, 99) < 8) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ord, b};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic push_word(input logic cmd, input logic [7:0] b, input logic last,
                             input logic [ORD_W-1:0] ord, input logic typed,
                             input t_answer fixed);
        t_answer ans;
        send_word(cmd, b, last, ord);
        if (apply_word(cmd, b, last, ord, ans)) answers_due.push_back(typed ? fixed : ans);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_size(input logic [LOG2_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        size_log2 = v;
    endtask

    task automatic send_ident();
        t_ident w;
        logic cmd;
        logic [ORD_W-1:0] ord;
        int unsigned pick, roll;
        pick = $urandom_range(0, POOL - 1);
        if ($urandom_range(0, 99) < 70) begin
            w = names[pick];
        end else begin
            w = fresh_ident();
            if ($urandom_range(0, 1) == 1) names[pick] = w;
        end
        cmd = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 45) ord = w.ord;
        else if (roll < 50) ord = ORD_RESERVED;
        else if (roll < 54) ord = '0;
        else ord = $urandom;
        for (int i = 0; i <= w.len_m1; i++) begin
            if (i == w.len_m1) push_word(cmd, w.text[i], 1'b1, ord, 1'b0, NO_ANSWER);
            else push_word(1'($urandom_range(0, 1)), w.text[i], 1'b0, $urandom, 1'b0, NO_ANSWER);
        end
    endtask

    task automatic report_bad(input string why, input t_answer want, input t_answer got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected status %0d ordinal %h slot %0d, got %0d %h %0d",
                     $time, why, want.status, want.ord, want.slot,
                     got.status, got.ord, got.slot);
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = '{t_status'(m_axis_tuser), m_axis_tdata[31:0], m_axis_tdata[43:32]};
            results_seen++;
            if (seen.status <= ST_MISSING) status_tally[int'(seen.status)]++;
            if (answers_due.size() == 0) begin
                report_bad("answer word with none due", NO_ANSWER, seen);
            end else begin
                due = answers_due.pop_front();
                if (seen.status != due.status || seen.ord != due.ord || seen.slot != due.slot)
                    report_bad("answer word mismatch", due, seen);
            end
        end
    end

    initial begin
        int unsigned phase, phase_start, random_start;
        bit paused;
        foreach (ord_plus_one_mem[s]) begin
            ord_plus_one_mem[s] = '0;
            key_lo_mem[s] = '0;
            key_hi_mem[s] = '0;
        end
        foreach (names[n]) names[n] = fresh_ident();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < ROWS; r++) begin
            if (PLAN[r].kind == ROW_SIZE) set_size(PLAN[r].ord[LOG2_W-1:0]);
            else push_word(PLAN[r].cmd, PLAN[r].id, PLAN[r].last, PLAN[r].ord,
                           PLAN[r].typed, PLAN[r].fixed);
        end

        phase = 0;
        random_start = words_sent;
        while (words_sent < random_start + RANDOM_WORDS) begin
            set_size(SIZE_SEQ[phase % 12]);
            steady = (phase == 5);
            phase_start = words_sent;
            paused = 1'b0;
            while (words_sent < phase_start + PHASE_WORDS) begin
                // let the table go quiet partway through each phase
                if (!paused && words_sent >= phase_start + 60) begin
                    drain();
                    paused = 1'b1;
                end
                send_ident();
            end
            phase++;
        end
        steady = 1'b0;
        drain();

        $display("run covered %0d byte words and %0d answer words over %0d table size phases",
                 words_sent, results_seen, phase);
        $display("answers: %0d inserted, %0d same, %0d conflict, %0d full, %0d found, %0d missing",
                 status_tally[0], status_tally[1], status_tally[2],
                 status_tally[3], status_tally[4], status_tally[5]);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("PASS hashed_id_table_insert_lookup");
        end else begin
            $display("FAIL hashed_id_table_insert_lookup");
        end
        $finish;
    end

    initial begin
        #(50_000_000);
        $display("timeout with %0d answer words still due", answers_due.size());
        $display("FAIL hashed_id_table_insert_lookup");
        $finish;
    end

endmodule

// ===== hashed_id_table_insert_lookup.f =====
sv/hitl_pkg.sv
sv/hitl_ram.sv
sv/hitl_hash.sv
sv/hitl_probe.sv
sv/hashed_id_table_insert_lookup.sv
tb/tb_hashed_id_table_insert_lookup.sv
